// ===== rtl/flr_pkg.sv =====
`default_nettype none

package flr_pkg;

   localparam int BYTE_W = 8;
   localparam logic [BYTE_W-1:0] START_CHAR = 8'h61;
   localparam logic [BYTE_W-1:0] DEVICE_ID_RESET = 8'h2d;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ID_FIRST = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ID_SECOND = 1'b1;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/fixed_length_frame_receiver.sv =====
// Output: a matching frame's payload reaches rsp once the last byte sets done_ff and
//   the output row loads; then one payload byte per cycle while rsp_ready is high.
// Throughput: one rx byte per cycle. The last byte of a frame waits while the
//   previous payload still sits in the output cell row.
// Reset: synchronous, active high; clears frame position and output count, and
//   sets both identifier registers to '-'.
`default_nettype none

module fixed_length_frame_receiver #(
   parameter int PAYLOAD_LEN = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [flr_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [flr_pkg::BYTE_W-1:0] rsp_payload_char,
   output logic                       rsp_payload_last,
   input  logic                       csr_write_enable,
   input  logic [flr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [flr_pkg::BYTE_W-1:0] csr_write_data
);
   import flr_pkg::*;

   localparam int FRAME_LEN = PAYLOAD_LEN + 3;
   localparam int STORE_LEN = PAYLOAD_LEN + 2;
   localparam int POS_W = $clog2(FRAME_LEN);
   localparam int CNT_W = $clog2(PAYLOAD_LEN + 1);

   logic [BYTE_W-1:0] id_first_ff, id_first_in;
   logic [BYTE_W-1:0] id_second_ff, id_second_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic accept, store, match, load, pop;
   cell_ctl_type cap_ctl, out_ctl;

   logic [BYTE_W-1:0] cap_data [STORE_LEN];
   logic [BYTE_W-1:0] out_data [PAYLOAD_LEN];

   assign req_ready = !(pos_ff == POS_W'(FRAME_LEN - 1) && count_ff != '0);
   assign accept = req_valid && req_ready;
   assign store = accept && req_rx_byte != START_CHAR && pos_ff != '0;

   assign match = cap_data[STORE_LEN-1] == id_first_ff && cap_data[STORE_LEN-2] == id_second_ff;
   assign load = done_ff && match;
   assign pop = rsp_valid && rsp_ready;

   assign rsp_valid = count_ff != '0;
   assign rsp_payload_char = out_data[0];
   assign rsp_payload_last = count_ff == CNT_W'(1);

   always_comb begin
      cap_ctl.shift = store;
      cap_ctl.load = 1'b0;
      out_ctl.shift = pop;
      out_ctl.load = load;
   end

   always_comb begin
      pos_in = pos_ff;
      done_in = 1'b0;
      if (accept) begin
         if (req_rx_byte == START_CHAR) begin
            pos_in = POS_W'(1);
         end else if (pos_ff == '0) begin
            pos_in = '0;
         end else if (pos_ff == POS_W'(FRAME_LEN - 1)) begin
            pos_in = '0;
            done_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = CNT_W'(PAYLOAD_LEN);
      end else if (pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      id_first_in = id_first_ff;
      id_second_in = id_second_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEVICE_ID_FIRST:  id_first_in = csr_write_data;
            CSR_DEVICE_ID_SECOND: id_second_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_first_ff <= DEVICE_ID_RESET;
         id_second_ff <= DEVICE_ID_RESET;
         pos_ff <= '0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         id_first_ff <= id_first_in;
         id_second_ff <= id_second_in;
         pos_ff <= pos_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   // capture row: newest byte in cell 0, first identifier byte ends in the top cell
   for (genvar i = 0; i < STORE_LEN; i++) begin : g_cap
      logic [BYTE_W-1:0] prev;
      if (i == 0) begin : g_head
         assign prev = req_rx_byte;
      end else begin : g_body
         assign prev = cap_data[i-1];
      end
      flr_cell #(.WIDTH(BYTE_W)) u_cell (
         .clock      (clock),
         .ctl        (cap_ctl),
         .shift_data (prev),
         .load_data  ('0),
         .data       (cap_data[i])
      );
   end

   // output row: cell 0 drives rsp, shifts toward it on each transaction
   for (genvar j = 0; j < PAYLOAD_LEN; j++) begin : g_out
      logic [BYTE_W-1:0] next;
      if (j == PAYLOAD_LEN - 1) begin : g_tail
         assign next = '0;
      end else begin : g_body
         assign next = out_data[j+1];
      end
      flr_cell #(.WIDTH(BYTE_W)) u_cell (
         .clock      (clock),
         .ctl        (out_ctl),
         .shift_data (next),
         .load_data  (cap_data[PAYLOAD_LEN-1-j]),
         .data       (out_data[j])
      );
   end

endmodule

`default_nettype wire

// ===== rtl/flr_cell.sv =====
`default_nettype none

module flr_cell #(
   parameter int WIDTH = 8
) (
   input  logic                clock,
   input  flr_pkg::cell_ctl_type ctl,
   input  logic [WIDTH-1:0]    shift_data,
   input  logic [WIDTH-1:0]    load_data,
   output logic [WIDTH-1:0]    data
);
   import flr_pkg::*;

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== rtl/flr_checker.sv =====
`default_nettype none

module flr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [flr_pkg::BYTE_W-1:0] rsp_payload_char,
   input logic                       rsp_payload_last
);
   import flr_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_char)
         && $stable(rsp_payload_last))
      else $error("stalled rsp transaction changed");

   a_no_start_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_char != START_CHAR)
      else $error("start character in payload");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload_last |=> rsp_valid)
      else $error("payload burst broken before last");

endmodule

bind fixed_length_frame_receiver flr_checker u_flr_checker (.*);

`default_nettype wire
